// ===== rtl/core/hps_pkg.sv =====
// ============================================================================
// hps_pkg: shared constants and types for the helix pitch setpoint block
// Field widths, register indexes, status codes and the sequencer encodings.
// ============================================================================
package hps_pkg;

    // Table depth default; the top level takes it as a parameter.
    localparam int MAX_SEGMENTS_DEF = 16;

    // Fixed field widths.
    localparam int LEN_W   = 24;
    localparam int PITCH_W = 24;
    localparam int DIST_W  = 28;
    localparam int VEL_W   = 32;
    localparam int SPT_W   = 20;
    localparam int GAIN_W  = 32;
    localparam int MAXV_W  = 31;
    localparam int MAXD_W  = 24;
    localparam int SCNT_W  = 5;

    // Shared divider: 48 bit dividend, 27 bit divisor (ten times a pitch).
    localparam int DIVD_W  = 48;
    localparam int DVS_W   = 27;

    // Configuration register indexes.
    localparam int          CFG_IDX_W       = 3;
    localparam logic [2:0]  CFG_REF_POS     = 3'd0;
    localparam logic [2:0]  CFG_MAX_DIST    = 3'd1;
    localparam logic [2:0]  CFG_SEG_COUNT   = 3'd2;
    localparam logic [2:0]  CFG_STEPS_TURN  = 3'd3;
    localparam logic [2:0]  CFG_VEL_GAIN    = 3'd4;
    localparam logic [2:0]  CFG_MAX_ROT_VEL = 3'd5;

    // Result status codes.
    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_TOO_FAR  = 2'd1;
    localparam logic [1:0]  ST_NEG_PITCH = 2'd2;
    localparam logic [1:0]  ST_POS_OVF  = 2'd3;

    // Input opcodes.
    localparam logic        OP_LOAD  = 1'b0;
    localparam logic        OP_QUERY = 1'b1;

    // What the divider result feeds.
    typedef enum logic [1:0] {
        JOB_EARLY = 2'd0,
        JOB_CUR   = 2'd1,
        JOB_VEL   = 2'd2
    } t_job;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_FRD    = 11'b000_0000_0010,
        S_FCHK   = 11'b000_0000_0100,
        S_PRD    = 11'b000_0000_1000,
        S_PCHK   = 11'b000_0001_0000,
        S_VEL    = 11'b000_0010_0000,
        S_MUL    = 11'b000_0100_0000,
        S_DIV    = 11'b000_1000_0000,
        S_DIVEND = 11'b001_0000_0000,
        S_FIN    = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

endpackage

// ===== rtl/core/helix_pitch_setpoint.sv =====
// ============================================================================
// helix_pitch_setpoint: rotation setpoints for a helical scan
// Holds a table of helix segments and turns a measured distance into a
// rotation position setpoint and a clamped rotation velocity setpoint.
// ============================================================================
//
// Channel   | Direction | Request when              | Carries
// ----------+-----------+---------------------------+--------------------------
// s_axis    | in        | tvalid && tready          | load entry or distance query
// m_axis    | out       | tvalid && tready          | one result per input request
// cfg       | in        | i_cfg_valid && o_cfg_ready| register index and write data
//
// A load, or a query beyond the maximum distance, passes through the output state
// into the output register. A query searches N segments, then reads each earlier
// segment, dividing once for each of the K earlier segments with a positive pitch
// and not for the J others; if the current pitch is not zero, it then divides for
// the current segment and for the velocity. Each division uses the shared
// one-bit-per-cycle divider (48 steps). The next request is taken once the
// sequencer is back in idle after the result.
// Reset is synchronous and active low; it restores the register defaults and
// empties the output register. The segment table itself is not cleared.
// A stalled result sits in the output register, and the next request is
// taken as soon as the sequencer is idle, even while that result waits.
// Configuration writes are taken only while the sequencer is idle.

module helix_pitch_setpoint #(
    parameter int MAX_SEGMENTS = hps_pkg::MAX_SEGMENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: seg_index[3:0], seg_length_mm[27:4], seg_pitch_mm[51:28],
    // distance_dmm[79:52], trans_velocity[111:80], current_rot_velocity[143:112]
    input  logic [143:0] s_axis_tdata,
    // tuser: op[0]
    input  logic         s_axis_tuser,
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: status[1:0], position_setpoint[33:2], rot_velocity[65:34],
    // velocity_clamped[66], velocity_changed[67], zero fill [71:68]
    output logic [71:0]  m_axis_tdata,
    // Configuration writes.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [hps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int LSUM_W = hps_pkg::LEN_W + $clog2(MAX_SEGMENTS);
    localparam int L10_W  = LSUM_W + 4;
    localparam int ACC_W  = 46 + $clog2(MAX_SEGMENTS);
    localparam int ENT_W  = hps_pkg::LEN_W + hps_pkg::PITCH_W;
    localparam int DCNT_W = $clog2(hps_pkg::DIVD_W);

    // Input fields.
    logic                               in_op;
    logic [3:0]                         in_seg_index;
    logic [hps_pkg::LEN_W-1:0]          in_len;
    logic [hps_pkg::PITCH_W-1:0]        in_pitch;
    logic [hps_pkg::DIST_W-1:0]         in_dist;
    logic [hps_pkg::VEL_W-1:0]          in_tv;
    logic [hps_pkg::VEL_W-1:0]          in_crv;

    assign in_op        = s_axis_tuser;
    assign in_seg_index = s_axis_tdata[3:0];
    assign in_len       = s_axis_tdata[27:4];
    assign in_pitch     = s_axis_tdata[51:28];
    assign in_dist      = s_axis_tdata[79:52];
    assign in_tv        = s_axis_tdata[111:80];
    assign in_crv       = s_axis_tdata[143:112];

    // Configuration registers.
    logic [31:0]                        r_ref_pos;
    logic [hps_pkg::MAXD_W-1:0]         r_max_dist;
    logic [hps_pkg::SCNT_W-1:0]         r_seg_count;
    logic [hps_pkg::SPT_W-1:0]          r_spt;
    logic [hps_pkg::GAIN_W-1:0]         r_gain;
    logic [hps_pkg::MAXV_W-1:0]         r_max_vel;

    // Sequencer and datapath registers.
    hps_pkg::t_state                    r_state;
    hps_pkg::t_job                      r_job;
    logic [hps_pkg::DIST_W-1:0]         r_dist;
    logic [hps_pkg::VEL_W-1:0]          r_tv;
    logic [hps_pkg::VEL_W-1:0]          r_crv;
    logic [CNT_W-1:0]                   r_cnt;
    logic [IDX_W-1:0]                   r_idx;
    logic [IDX_W-1:0]                   r_cur;
    logic [LSUM_W-1:0]                  r_lsum;
    logic signed [ACC_W-1:0]            r_acc;
    logic                               r_neg;
    logic [hps_pkg::PITCH_W-1:0]        r_pcur;
    logic [31:0]                        r_mul_a;
    logic [31:0]                        r_mul_b;
    logic [hps_pkg::DIVD_W-1:0]         r_div_num;
    logic [hps_pkg::DVS_W-1:0]          r_rem;
    logic [hps_pkg::DVS_W-1:0]          r_dvs;
    logic [DCNT_W-1:0]                  r_div_cnt;
    logic [31:0]                        r_vel;
    logic                               r_clamped;
    logic [1:0]                         r_res_status;
    logic [31:0]                        r_res_pos;
    logic                               r_out_valid;
    logic [71:0]                        r_out_data;
    logic                               r_is_query;
    logic                               out_changed;

    // Segment table: length in the upper half, pitch in the lower half.
    logic [ENT_W-1:0]                   mem_seg [MAX_SEGMENTS];
    logic [ENT_W-1:0]                   r_rdata;
    logic                               mem_we;

    logic in_req;
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == hps_pkg::S_IDLE);
    assign o_cfg_ready   = (r_state == hps_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign mem_we = in_req && (in_op == hps_pkg::OP_LOAD)
                    && (int'(in_seg_index) < MAX_SEGMENTS);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_seg[IDX_W'(in_seg_index)] <= {in_len, in_pitch};
        end
        r_rdata <= mem_seg[r_idx];
    end

    // Combinational helpers.
    logic [hps_pkg::LEN_W-1:0]          rd_len;
    logic signed [hps_pkg::PITCH_W-1:0] rd_pitch;
    logic [LSUM_W-1:0]                  n_lsum;
    logic [L10_W-1:0]                   n_lsum10;
    logic [L10_W-1:0]                   lsum10;
    logic [L10_W-1:0]                   max10;
    logic [CNT_W-1:0]                   n_cnt;
    logic [hps_pkg::DIST_W-1:0]         n_diff;
    logic [hps_pkg::PITCH_W-1:0]        rd_abs_p;
    logic [hps_pkg::PITCH_W-1:0]        cur_abs_p;
    logic [31:0]                        tv_abs;
    logic [63:0]                        n_prod;
    logic [hps_pkg::DVS_W:0]            rem_sh;
    logic                               qbit;
    logic signed [ACC_W-1:0]            q_ext;
    logic [hps_pkg::MAXV_W-1:0]         vel_mag;
    logic                               vel_clamp;
    logic signed [ACC_W-1:0]            acc_hi;
    logic signed [ACC_W-1:0]            acc_lo;

    always_comb begin
        rd_len    = r_rdata[ENT_W-1:hps_pkg::PITCH_W];
        rd_pitch  = $signed(r_rdata[hps_pkg::PITCH_W-1:0]);
        n_lsum    = r_lsum + LSUM_W'(rd_len);
        n_lsum10  = L10_W'({n_lsum, 3'b000}) + L10_W'({n_lsum, 1'b0});
        lsum10    = L10_W'({r_lsum, 3'b000}) + L10_W'({r_lsum, 1'b0});
        max10     = L10_W'({r_max_dist, 3'b000}) + L10_W'({r_max_dist, 1'b0});
        if (int'(r_seg_count) > MAX_SEGMENTS) begin
            n_cnt = CNT_W'(MAX_SEGMENTS);
        end else begin
            n_cnt = CNT_W'(r_seg_count);
        end
        // The prefix never passes the distance here, so the difference fits.
        n_diff    = r_dist - hps_pkg::DIST_W'(lsum10);
        rd_abs_p  = rd_pitch[hps_pkg::PITCH_W-1] ? (~rd_pitch + 1'b1) : rd_pitch;
        cur_abs_p = r_pcur[hps_pkg::PITCH_W-1] ? (~r_pcur + 1'b1) : r_pcur;
        tv_abs    = r_tv[31] ? (~r_tv + 1'b1) : r_tv;
        n_prod    = r_mul_a * r_mul_b;
        rem_sh    = {r_rem, r_div_num[hps_pkg::DIVD_W-1]};
        qbit      = (rem_sh >= {1'b0, r_dvs});
        q_ext     = $signed(ACC_W'(r_div_num));
        vel_clamp = (r_div_num > hps_pkg::DIVD_W'(r_max_vel));
        vel_mag   = vel_clamp ? r_max_vel : r_div_num[hps_pkg::MAXV_W-1:0];
        acc_hi    = $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF});
        acc_lo    = $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hps_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ref_pos   <= '0;
            r_max_dist  <= '0;
            r_seg_count <= hps_pkg::SCNT_W'(1);
            r_spt       <= hps_pkg::SPT_W'(1);
            r_gain      <= 32'h0001_0000;
            r_max_vel   <= '1;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hps_pkg::CFG_REF_POS:     r_ref_pos   <= i_cfg_data;
                    hps_pkg::CFG_MAX_DIST:    r_max_dist  <= i_cfg_data[hps_pkg::MAXD_W-1:0];
                    hps_pkg::CFG_SEG_COUNT:   r_seg_count <= i_cfg_data[hps_pkg::SCNT_W-1:0];
                    hps_pkg::CFG_STEPS_TURN:  r_spt       <= i_cfg_data[hps_pkg::SPT_W-1:0];
                    hps_pkg::CFG_VEL_GAIN:    r_gain      <= i_cfg_data;
                    hps_pkg::CFG_MAX_ROT_VEL: r_max_vel   <= i_cfg_data[hps_pkg::MAXV_W-1:0];
                    default: ;
                endcase
            end

            // In the output state a taken result is replaced in the same cycle.
            if (r_out_valid && m_axis_tready && (r_state != hps_pkg::S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                hps_pkg::S_IDLE: begin
                    if (in_req) begin
                        r_dist       <= in_dist;
                        r_tv         <= in_tv;
                        r_crv        <= in_crv;
                        r_res_pos    <= '0;
                        r_vel        <= '0;
                        r_clamped    <= 1'b0;
                        r_idx        <= '0;
                        r_lsum       <= '0;
                        r_cur        <= '0;
                        r_cnt        <= n_cnt;
                        if (in_op == hps_pkg::OP_LOAD) begin
                            r_res_status <= hps_pkg::ST_OK;
                            r_state      <= hps_pkg::S_OUT;
                        end else if (L10_W'(in_dist) > max10) begin
                            r_res_status <= hps_pkg::ST_TOO_FAR;
                            r_state      <= hps_pkg::S_OUT;
                        end else if (n_cnt == '0) begin
                            r_res_status <= hps_pkg::ST_OK;
                            r_acc        <= ACC_W'($signed(r_ref_pos));
                            r_neg        <= 1'b0;
                            r_state      <= hps_pkg::S_PRD;
                        end else begin
                            r_res_status <= hps_pkg::ST_OK;
                            r_state      <= hps_pkg::S_FRD;
                        end
                    end
                end
                hps_pkg::S_FRD: begin
                    r_state <= hps_pkg::S_FCHK;
                end
                hps_pkg::S_FCHK: begin
                    // Search for the first segment whose running length reaches D.
                    if (L10_W'(r_dist) <= n_lsum10) begin
                        r_cur   <= r_idx;
                        r_idx   <= '0;
                        r_lsum  <= '0;
                        r_acc   <= ACC_W'($signed(r_ref_pos));
                        r_neg   <= 1'b0;
                        r_state <= hps_pkg::S_PRD;
                    end else if (CNT_W'(r_idx) + 1'b1 == r_cnt) begin
                        // Nothing reached: fall back to segment 0.
                        r_cur   <= '0;
                        r_idx   <= '0;
                        r_lsum  <= '0;
                        r_acc   <= ACC_W'($signed(r_ref_pos));
                        r_neg   <= 1'b0;
                        r_state <= hps_pkg::S_PRD;
                    end else begin
                        r_lsum  <= n_lsum;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= hps_pkg::S_FRD;
                    end
                end
                hps_pkg::S_PRD: begin
                    r_state <= hps_pkg::S_PCHK;
                end
                hps_pkg::S_PCHK: begin
                    if (r_idx != r_cur) begin
                        // Whole earlier segment.
                        r_lsum  <= n_lsum;
                        r_mul_a <= 32'(rd_len);
                        r_mul_b <= 32'(r_spt);
                        r_dvs   <= hps_pkg::DVS_W'(rd_abs_p);
                        r_job   <= hps_pkg::JOB_EARLY;
                        if (rd_pitch < 0) begin
                            r_neg   <= 1'b1;
                            r_idx   <= r_idx + 1'b1;
                            r_state <= hps_pkg::S_PRD;
                        end else if (rd_pitch > 0) begin
                            r_state <= hps_pkg::S_MUL;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= hps_pkg::S_PRD;
                        end
                    end else begin
                        // Partial current segment.
                        r_pcur  <= rd_pitch;
                        r_mul_a <= 32'(n_diff);
                        r_mul_b <= 32'(r_spt);
                        r_dvs   <= {rd_abs_p, 3'b000} + {2'b00, rd_abs_p, 1'b0};
                        r_job   <= hps_pkg::JOB_CUR;
                        r_state <= (rd_pitch != 0) ? hps_pkg::S_MUL : hps_pkg::S_FIN;
                    end
                end
                hps_pkg::S_VEL: begin
                    r_mul_a <= tv_abs;
                    r_mul_b <= r_gain;
                    r_dvs   <= hps_pkg::DVS_W'(cur_abs_p);
                    r_job   <= hps_pkg::JOB_VEL;
                    r_state <= hps_pkg::S_MUL;
                end
                hps_pkg::S_MUL: begin
                    // The gain is Q16.16: drop the fraction before dividing.
                    if (r_job == hps_pkg::JOB_VEL) begin
                        r_div_num <= n_prod[63:16];
                    end else begin
                        r_div_num <= n_prod[hps_pkg::DIVD_W-1:0];
                    end
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_state   <= hps_pkg::S_DIV;
                end
                hps_pkg::S_DIV: begin
                    r_rem     <= qbit ? hps_pkg::DVS_W'(rem_sh - {1'b0, r_dvs})
                                      : hps_pkg::DVS_W'(rem_sh);
                    r_div_num <= {r_div_num[hps_pkg::DIVD_W-2:0], qbit};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DCNT_W'(hps_pkg::DIVD_W - 1)) begin
                        r_state <= hps_pkg::S_DIVEND;
                    end
                end
                hps_pkg::S_DIVEND: begin
                    case (r_job)
                        hps_pkg::JOB_EARLY: begin
                            r_acc   <= r_acc + q_ext;
                            r_idx   <= r_idx + 1'b1;
                            r_state <= hps_pkg::S_PRD;
                        end
                        hps_pkg::JOB_CUR: begin
                            r_acc   <= r_pcur[hps_pkg::PITCH_W-1] ? (r_acc - q_ext)
                                                                  : (r_acc + q_ext);
                            r_state <= hps_pkg::S_VEL;
                        end
                        default: begin
                            r_clamped <= vel_clamp;
                            r_vel     <= (r_tv[31] != r_pcur[hps_pkg::PITCH_W-1])
                                         ? (32'd0 - {1'b0, vel_mag}) : {1'b0, vel_mag};
                            r_state   <= hps_pkg::S_FIN;
                        end
                    endcase
                end
                hps_pkg::S_FIN: begin
                    if (r_neg) begin
                        r_res_status <= hps_pkg::ST_NEG_PITCH;
                        r_res_pos    <= '0;
                    end else if (r_acc > acc_hi) begin
                        r_res_status <= hps_pkg::ST_POS_OVF;
                        r_res_pos    <= 32'h7FFF_FFFF;
                    end else if (r_acc <= acc_lo) begin
                        r_res_status <= hps_pkg::ST_POS_OVF;
                        r_res_pos    <= 32'h8000_0000;
                    end else begin
                        r_res_status <= hps_pkg::ST_OK;
                        r_res_pos    <= r_acc[31:0];
                    end
                    r_state <= hps_pkg::S_OUT;
                end
                hps_pkg::S_OUT: begin
                    // Hand over once the output register is free.
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'b0000, out_changed, r_clamped, r_vel,
                                        r_res_pos, r_res_status};
                        r_state     <= hps_pkg::S_IDLE;
                    end
                end
                default: r_state <= hps_pkg::S_IDLE;
            endcase
        end
    end

    // A load result is all zero; a query that is not too far compares its velocity with the applied one.
    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_is_query <= (in_op == hps_pkg::OP_QUERY);
        end
    end
    assign out_changed = r_is_query && (r_res_status != hps_pkg::ST_TOO_FAR)
                         && (r_vel != r_crv);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |=> !s_axis_tready)
        else $error("request taken while an item is in progress");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hps_pkg::S_DIV) |-> (int'(r_div_cnt) < hps_pkg::DIVD_W))
        else $error("divider ran past its step count");

    a_neg_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == hps_pkg::ST_NEG_PITCH)
        |-> (m_axis_tdata[33:2] == 32'd0))
        else $error("negative pitch result carries a position");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == hps_pkg::ST_POS_OVF)
        |-> (m_axis_tdata[33:2] == 32'h7FFF_FFFF || m_axis_tdata[33:2] == 32'h8000_0000))
        else $error("overflow result not saturated");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the helix pitch setpoint block
// Loads segment tables, writes every register over several phases and checks
// every result against a cycle-free model of the setpoint arithmetic.
// ============================================================================
module testbench;

    localparam int NSEG = 16;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [hps_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    helix_pitch_setpoint dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // One request on the input stream.
    typedef struct packed {
        logic        op;
        logic [3:0]  idx;
        logic [23:0] len;
        logic [23:0] pitch;
        logic [27:0] dist_dmm;
        logic [31:0] tvel;
        logic [31:0] cvel;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pos;
        logic [31:0] vel;
        logic        clamped;
        logic        changed;
    } t_setpoint;

    // Model copy of the table and registers.
    longint seg_len [NSEG];
    longint seg_pitch [NSEG];
    longint m_ref_pos, m_max_dist, m_seg_cnt, m_spt, m_gain, m_max_vel;

    t_setpoint pending_setpoints[$];
    int  mismatches = 0;
    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  hold_off = 1'b0;

    function automatic t_setpoint compute_setpoint(t_req r);
        t_setpoint sp;
        longint dist_v, lsum, pos, p, tv, q;
        int cnt, cur;
        bit neg;
        sp = '0;
        if (r.op == hps_pkg::OP_LOAD) begin
            seg_len[r.idx] = r.len;
            seg_pitch[r.idx] = longint'(signed'(r.pitch));
            return sp;
        end
        dist_v = r.dist_dmm;
        if (dist_v > 10 * m_max_dist) begin
            sp.status = hps_pkg::ST_TOO_FAR;
            return sp;
        end
        cnt = (m_seg_cnt > NSEG) ? NSEG : int'(m_seg_cnt);
        cur = 0;
        lsum = 0;
        for (int i = 0; i < cnt; i++) begin
            lsum += seg_len[i];
            if (dist_v <= 10 * lsum) begin
                cur = i;
                break;
            end
        end
        pos = m_ref_pos;
        lsum = 0;
        neg = 1'b0;
        for (int i = 0; i < cur; i++) begin
            p = seg_pitch[i];
            if (p < 0) neg = 1'b1;
            else if (p > 0) pos += (seg_len[i] * m_spt) / p;
            lsum += seg_len[i];
        end
        p = seg_pitch[cur];
        if (p != 0) pos += ((dist_v - 10 * lsum) * m_spt) / (10 * p);
        sp.status = hps_pkg::ST_OK;
        if (neg) begin
            sp.status = hps_pkg::ST_NEG_PITCH;
            pos = 0;
        end else if (pos > 64'sh7FFFFFFF || pos <= -64'sh80000000) begin
            sp.status = hps_pkg::ST_POS_OVF;
            pos = (pos > 0) ? 64'sh7FFFFFFF : -64'sh80000000;
        end
        sp.pos = pos[31:0];
        q = 0;
        if (p != 0) begin
            longint unsigned mag, den, uq;
            tv = longint'(signed'(r.tvel));
            mag = longint'(tv < 0 ? -tv : tv) * m_gain;
            den = longint'(p < 0 ? -p : p) * 65536;
            uq = mag / den;
            if (uq > m_max_vel) begin
                uq = m_max_vel;
                sp.clamped = 1'b1;
            end
            q = ((tv < 0) != (p < 0)) ? -longint'(uq) : longint'(uq);
        end
        sp.vel = q[31:0];
        sp.changed = (q[31:0] != r.cvel);
        return sp;
    endfunction

    task automatic write_reg(logic [hps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            hps_pkg::CFG_REF_POS:     m_ref_pos  = longint'(signed'(val));
            hps_pkg::CFG_MAX_DIST:    m_max_dist = val[23:0];
            hps_pkg::CFG_SEG_COUNT:   m_seg_cnt  = val[4:0];
            hps_pkg::CFG_STEPS_TURN:  m_spt      = val[19:0];
            hps_pkg::CFG_VEL_GAIN:    m_gain     = val;
            hps_pkg::CFG_MAX_ROT_VEL: m_max_vel  = val[30:0];
            default: ;
        endcase
    endtask

    // Sends one request; an expected value typed in the table replaces the model's.
    // tvalid stays high after a request until the next one or an idle cycle.
    task automatic send_request(t_req r, bit has_exp = 0, t_setpoint exp_sp = '0);
        t_setpoint sp;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {r.cvel, r.tvel, r.dist_dmm, r.pitch, r.len, r.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sp = compute_setpoint(r);
        pending_setpoints.push_back(has_exp ? exp_sp : sp);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_setpoint got, want;
            got = '{m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
                    m_axis_tdata[66], m_axis_tdata[67]};
            if (pending_setpoints.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_setpoints.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.pos !== want.pos) begin
                    $error("position_setpoint exp %0d got %0d",
                           $signed(want.pos), $signed(got.pos));
                    mismatches++;
                end
                if (got.vel !== want.vel) begin
                    $error("rot_velocity exp %0d got %0d",
                           $signed(want.vel), $signed(got.vel));
                    mismatches++;
                end
                if (got.clamped !== want.clamped) begin
                    $error("velocity_clamped exp %0b got %0b", want.clamped, got.clamped);
                    mismatches++;
                end
                if (got.changed !== want.changed) begin
                    $error("velocity_changed exp %0b got %0b", want.changed, got.changed);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    function automatic t_req load_req(int idx, int len, int pitch);
        t_req r;
        r = '0;
        r.op = hps_pkg::OP_LOAD;
        r.idx = 4'(idx);
        r.len = 24'(len);
        r.pitch = 24'(pitch);
        return r;
    endfunction

    function automatic t_req query_req(int dist_dmm, int tvel, int cvel);
        t_req r;
        r = '0;
        r.op = hps_pkg::OP_QUERY;
        r.dist_dmm = 28'(dist_dmm);
        r.tvel = tvel;
        r.cvel = cvel;
        return r;
    endfunction

    // Random request: mostly queries over a fully written table.
    function automatic t_req random_req();
        t_req r;
        r.op = ($urandom_range(99) < 70) ? hps_pkg::OP_QUERY : hps_pkg::OP_LOAD;
        r.idx = 4'($urandom);
        case ($urandom_range(3))
            0: r.len = 24'($urandom_range(1, 20));
            1: r.len = 24'($urandom);
            default: r.len = 24'($urandom_range(0, 5000));
        endcase
        case ($urandom_range(4))
            0: r.pitch = '0;
            1: r.pitch = 24'(-$urandom_range(1, 200));
            2: r.pitch = 24'($urandom);
            default: r.pitch = 24'($urandom_range(1, 500));
        endcase
        r.dist_dmm = ($urandom_range(3) == 0) ? 28'($urandom)
                                              : 28'($urandom_range(0, 60000));
        r.tvel = $urandom;
        if ($urandom_range(1)) r.tvel = $signed(r.tvel) >>> $urandom_range(31);
        r.cvel = $urandom;
        return r;
    endfunction

    typedef struct {
        t_req      r;
        bit        has_exp;
        t_setpoint exp_sp;
    } t_row;

    initial begin
        t_row rows[$];
        t_req r;
        int ncnt;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        m_ref_pos = 0; m_max_dist = 0; m_seg_cnt = 1; m_spt = 1;
        m_gain = 65536; m_max_vel = 32'h7FFFFFFF;

        // Directed part. After reset max distance is zero, so distance zero is
        // accepted and anything beyond is too far.
        rows.push_back('{load_req(0, 24'hFFFFFF, 24'h7FFFFF), 1, '0});
        rows.push_back('{load_req(15, 0, -8388608), 1, '0});
        rows.push_back('{query_req(1, 5, 0), 1, '{hps_pkg::ST_TOO_FAR, 0, 0, 0, 0}});
        rows.push_back('{query_req(28'hFFFFFFF, -1, -1), 1,
                         '{hps_pkg::ST_TOO_FAR, 0, 0, 0, 0}});
        rows.push_back('{query_req(0, 32'h7FFFFFFF, 0), 0, '0});
        foreach (rows[i]) send_request(rows[i].r, rows[i].has_exp, rows[i].exp_sp);
        drain();

        // A table with a zero, a negative and a positive pitch; extremes of registers.
        write_reg(hps_pkg::CFG_MAX_DIST, 32'hFFFFFF);
        write_reg(hps_pkg::CFG_SEG_COUNT, 4);
        write_reg(hps_pkg::CFG_STEPS_TURN, 32'hFFFFF);
        write_reg(hps_pkg::CFG_VEL_GAIN, 32'hFFFFFFFF);
        write_reg(hps_pkg::CFG_MAX_ROT_VEL, 1000);
        write_reg(hps_pkg::CFG_REF_POS, 32'h7FFFF000);
        rows.delete();
        rows.push_back('{load_req(0, 100, 10), 0, '0});
        rows.push_back('{load_req(1, 50, 0), 0, '0});
        rows.push_back('{load_req(2, 30, -7), 0, '0});
        rows.push_back('{load_req(3, 200, 1), 0, '0});
        rows.push_back('{load_req(31 & 15, 0, 3), 0, '0});
        rows.push_back('{query_req(0, 5, 5), 0, '0});
        rows.push_back('{query_req(999, -32'sd80000000, 0), 0, '0});
        rows.push_back('{query_req(1200, 123456, 0), 0, '0});
        rows.push_back('{query_req(1700, -77, 0), 0, '0});
        rows.push_back('{query_req(3000, 9, 0), 0, '0});
        rows.push_back('{query_req(28'hFFFFFFF, 1, 0), 0, '0});
        foreach (rows[i]) send_request(rows[i].r, rows[i].has_exp, rows[i].exp_sp);
        drain();
        write_reg(hps_pkg::CFG_REF_POS, 32'h80000000);
        write_reg(hps_pkg::CFG_SEG_COUNT, 0);
        send_request(query_req(400, 7, 0));
        drain();
        write_reg(hps_pkg::CFG_SEG_COUNT, 31);
        write_reg(hps_pkg::CFG_STEPS_TURN, 0);
        // Every entry is written before any query reaches it.
        for (int i = 0; i < NSEG; i++)
            send_request(load_req(i, $urandom_range(1, 400), $urandom_range(1, 50)));
        send_request(query_req(20000, -3, 0));
        drain();

        // Random phases, each with its own register setting and idle pattern.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 49 : 0;
            recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 12 : 0;
            ncnt = (ph == 0) ? 3 : (ph == 1) ? 16 : 8;
            write_reg(hps_pkg::CFG_REF_POS, $urandom);
            write_reg(hps_pkg::CFG_MAX_DIST,
                      (ph == 1) ? 32'hFFFFFF : $urandom_range(500, 20000));
            write_reg(hps_pkg::CFG_SEG_COUNT, ncnt);
            write_reg(hps_pkg::CFG_STEPS_TURN,
                      (ph == 2) ? 1 : $urandom_range(1, 32'hFFFFF));
            write_reg(hps_pkg::CFG_VEL_GAIN, (ph == 2) ? 0 : $urandom);
            write_reg(hps_pkg::CFG_MAX_ROT_VEL, (ph == 0) ? 0 : $urandom);
            for (int n = 0; n < 182; n++) begin
                if (ph == 1 && n == 40) begin
                    // Long result hold-off while requests keep coming.
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (3000) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                r = random_req();
                send_request(r);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/hps_pkg.sv
rtl/core/helix_pitch_setpoint.sv
tb/sv/testbench.sv
